/* design/hsv_pkg.sv */
// ============================================================================
// hsv_pkg: shared types and constants for the RGB to HSV converter
// Channel widths, divider lane layout and the word handed from the front
// end to the divider pipeline.
// ============================================================================
package hsv_pkg;

    // pixel channel width
    localparam int CHAN_W = 8;
    // widest divisor (6 * spread, at most 1530) and the hue numerator
    localparam int DEN_W = 11;
    // spread * 65535 fits in 24 bits
    localparam int SATNUM_W = 24;
    // output field widths
    localparam int HUE_W = 16;
    localparam int SAT_W = 16;

    // divider lanes
    localparam int LANES    = 2;
    localparam int LANE_SAT = 0;
    localparam int LANE_HUE = 1;

    // hue sector, picked with red, then green, then blue on ties
    typedef enum logic [1:0] {
        SEC_RED      = 2'd0,  // red max, green >= blue
        SEC_RED_WRAP = 2'd1,  // red max, green < blue (adds six sixths)
        SEC_GREEN    = 2'd2,  // green max
        SEC_BLUE     = 2'd3   // blue max
    } sector_t;

    // front end result, one per pixel
    typedef struct packed {
        logic                grey;    // all channels equal
        logic [CHAN_W-1:0]   bright;  // largest channel
        logic [DEN_W-1:0]    num;     // hue numerator, in [0, 6d)
        logic [DEN_W-1:0]    den6;    // 6 * spread
        logic [SATNUM_W-1:0] satnum;  // spread * 65535
    } prep_word_t;

endpackage

/* design/hsv_prep.sv */
// ============================================================================
// hsv_prep: front end of the converter
// Three register stages: input capture, max/min and sector pick, then the
// hue numerator, the divisor and the saturation numerator.
// ============================================================================
module hsv_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    output logic                 out_valid,
    output hsv_pkg::prep_word_t  out_word
);

    // stage 1: captured pixel
    logic                      v1_reg;
    logic [hsv_pkg::CHAN_W-1:0] r1_reg, g1_reg, b1_reg;

    // stage 2: max, min, sector, signed channel difference
    logic                      v2_reg;
    logic [hsv_pkg::CHAN_W-1:0] hi2_reg, lo2_reg;
    hsv_pkg::sector_t          sec2_reg;
    logic [hsv_pkg::CHAN_W:0]   diff2_reg;

    // stage 3: front end word
    logic                      v3_reg;
    hsv_pkg::prep_word_t       w3_reg;

    logic [hsv_pkg::CHAN_W-1:0] hi2_next, lo2_next;
    hsv_pkg::sector_t          sec2_next;
    logic [hsv_pkg::CHAN_W:0]   diff2_next;

    logic [hsv_pkg::CHAN_W-1:0] spread;
    logic [hsv_pkg::DEN_W:0]    kd;
    logic [hsv_pkg::DEN_W:0]    num_wide;
    hsv_pkg::prep_word_t       w3_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 2 logic: max/min with red, green, blue priority
    always_comb begin
        if (r1_reg >= g1_reg && r1_reg >= b1_reg) begin
            hi2_next   = r1_reg;
            sec2_next  = (g1_reg >= b1_reg) ? hsv_pkg::SEC_RED : hsv_pkg::SEC_RED_WRAP;
            diff2_next = {1'b0, g1_reg} - {1'b0, b1_reg};
        end else if (g1_reg >= b1_reg) begin
            hi2_next   = g1_reg;
            sec2_next  = hsv_pkg::SEC_GREEN;
            diff2_next = {1'b0, b1_reg} - {1'b0, r1_reg};
        end else begin
            hi2_next   = b1_reg;
            sec2_next  = hsv_pkg::SEC_BLUE;
            diff2_next = {1'b0, r1_reg} - {1'b0, g1_reg};
        end
        lo2_next = (r1_reg <= g1_reg) ? r1_reg : g1_reg;
        if (b1_reg < lo2_next) begin
            lo2_next = b1_reg;
        end
    end

    // stage 3 logic: sector offset times spread plus difference
    always_comb begin
        spread = hi2_reg - lo2_reg;
        unique case (sec2_reg)
            hsv_pkg::SEC_RED:      kd = '0;
            hsv_pkg::SEC_RED_WRAP: kd = ((hsv_pkg::DEN_W+1)'(spread) << 2)
                                      + ((hsv_pkg::DEN_W+1)'(spread) << 1);
            hsv_pkg::SEC_GREEN:    kd = (hsv_pkg::DEN_W+1)'(spread) << 1;
            hsv_pkg::SEC_BLUE:     kd = (hsv_pkg::DEN_W+1)'(spread) << 2;
            default:               kd = '0;
        endcase
        num_wide = kd + {{(hsv_pkg::DEN_W-hsv_pkg::CHAN_W){diff2_reg[hsv_pkg::CHAN_W]}},
                         diff2_reg};
        w3_next.grey   = (spread == '0);
        w3_next.bright = hi2_reg;
        w3_next.num    = num_wide[hsv_pkg::DEN_W-1:0];
        w3_next.den6   = (hsv_pkg::DEN_W'(spread) << 2) + (hsv_pkg::DEN_W'(spread) << 1);
        w3_next.satnum = (hsv_pkg::SATNUM_W'(spread) << 16) - hsv_pkg::SATNUM_W'(spread);
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg    <= red;
            g1_reg    <= green;
            b1_reg    <= blue;
            hi2_reg   <= hi2_next;
            lo2_reg   <= lo2_next;
            sec2_reg  <= sec2_next;
            diff2_reg <= diff2_next;
            w3_reg    <= w3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_word  = w3_reg;

endmodule

/* design/hsv_div.sv */
// ============================================================================
// hsv_div: pipelined restoring divider, two lanes
// One quotient bit per stage per lane; both quotients are QBITS wide.
// Saturation: spread * 65535 over the largest channel, QBITS-16 fraction bits.
// Hue: the numerator over 6 * spread, QBITS fraction bits.
// ============================================================================
module hsv_div #(
    parameter int QBITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  hsv_pkg::prep_word_t        in_word,
    output logic                       out_valid,
    output logic                       out_grey,
    output logic [hsv_pkg::CHAN_W-1:0] out_bright,
    output logic [QBITS-1:0]           out_sat_q,
    output logic [QBITS-1:0]           out_hue_q
);

    localparam int DW = hsv_pkg::DEN_W;

    // per stage registers
    logic                       v_reg      [1:QBITS];
    logic                       grey_reg   [1:QBITS];
    logic [hsv_pkg::CHAN_W-1:0] bright_reg [1:QBITS];
    logic [DW-1:0]              rem_reg    [1:QBITS][hsv_pkg::LANES];
    logic [DW-1:0]              den_reg    [1:QBITS][hsv_pkg::LANES];
    logic [QBITS-1:0]           low_reg    [1:QBITS][hsv_pkg::LANES];
    logic [QBITS-1:0]           quot_reg   [1:QBITS][hsv_pkg::LANES];

    for (genvar s = 1; s <= QBITS; s++) begin : g_stage
        logic                       src_valid;
        logic                       src_grey;
        logic [hsv_pkg::CHAN_W-1:0] src_bright;
        logic [DW-1:0]              src_rem  [hsv_pkg::LANES];
        logic [DW-1:0]              src_den  [hsv_pkg::LANES];
        logic [QBITS-1:0]           src_low  [hsv_pkg::LANES];
        logic [QBITS-1:0]           src_quot [hsv_pkg::LANES];

        // stage source: divider input or previous stage
        if (s == 1) begin : g_first
            assign src_valid  = in_valid;
            assign src_grey   = in_word.grey;
            assign src_bright = in_word.bright;
            // saturation: top byte starts the remainder, low 16 bits stream in
            assign src_rem[hsv_pkg::LANE_SAT]  = DW'(in_word.satnum[hsv_pkg::SATNUM_W-1:16]);
            assign src_den[hsv_pkg::LANE_SAT]  = DW'(in_word.bright);
            assign src_low[hsv_pkg::LANE_SAT]  = QBITS'(in_word.satnum[15:0]) << (QBITS - 16);
            assign src_quot[hsv_pkg::LANE_SAT] = '0;
            // hue: numerator shifted up by QBITS
            assign src_rem[hsv_pkg::LANE_HUE]  = in_word.num;
            assign src_den[hsv_pkg::LANE_HUE]  = in_word.den6;
            assign src_low[hsv_pkg::LANE_HUE]  = '0;
            assign src_quot[hsv_pkg::LANE_HUE] = '0;
        end else begin : g_next
            assign src_valid  = v_reg[s-1];
            assign src_grey   = grey_reg[s-1];
            assign src_bright = bright_reg[s-1];
            for (genvar l = 0; l < hsv_pkg::LANES; l++) begin : g_src
                assign src_rem[l]  = rem_reg[s-1][l];
                assign src_den[l]  = den_reg[s-1][l];
                assign src_low[l]  = low_reg[s-1][l];
                assign src_quot[l] = quot_reg[s-1][l];
            end
        end

        // valid bit of this stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                grey_reg[s]   <= src_grey;
                bright_reg[s] <= src_bright;
            end
        end

        // one compare and subtract per lane
        for (genvar l = 0; l < hsv_pkg::LANES; l++) begin : g_lane
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        fits;

            always_comb begin
                trial = {src_rem[l], src_low[l][QBITS-1]};
                diff  = trial - {1'b0, src_den[l]};
                fits  = (trial >= {1'b0, src_den[l]});
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s][l]  <= fits ? diff[DW-1:0] : trial[DW-1:0];
                    den_reg[s][l]  <= src_den[l];
                    low_reg[s][l]  <= src_low[l] << 1;
                    quot_reg[s][l] <= {src_quot[l][QBITS-2:0], fits};
                end
            end
        end
    end

    assign out_valid  = v_reg[QBITS];
    assign out_grey   = grey_reg[QBITS];
    assign out_bright = bright_reg[QBITS];
    assign out_sat_q  = quot_reg[QBITS][hsv_pkg::LANE_SAT];
    assign out_hue_q  = quot_reg[QBITS][hsv_pkg::LANE_HUE];

endmodule

/* design/rgb_to_hsv_converter_unit.sv */
// ============================================================================
// rgb_to_hsv_converter_unit: streaming RGB to HSV pixel converter
// Value is the largest channel, saturation spread*65535/max, hue a
// fraction of a turn scaled by 2^FRAC_BITS and kept to 16 bits.
// ============================================================================
//
//  channel | dir | word layout (low bit up)              | bytes
//  --------+-----+---------------------------------------+------
//  s_      | in  | red[7:0] green[15:8] blue[23:16]      | 3
//  m_      | out | hue[15:0] saturation[31:16]           | 5
//          |     | brightness[39:32]                     |
//
//  One pixel per clock in and out while m_ does not stall. The path runs
//  through three front end stages, one divider stage per quotient bit and
//  one output register. The bit-serial divider stages set the depth.
//  Reset clears valid bits only; there is no clearing pass.
//  A stall on m_ fills a one-word skid stage; s_tready drops only while the
//  skid stage holds a word, and the whole pipeline then holds.
//
module rgb_to_hsv_converter_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // hue[15:0], saturation[31:16], brightness[39:32]
);

    // divider width covers both the 16-bit saturation and the hue scaling
    localparam int QBITS     = (FRAC_BITS > 16) ? FRAC_BITS : 16;
    localparam int SAT_SHIFT = QBITS - 16;
    localparam int HUE_SHIFT = QBITS - FRAC_BITS;
    localparam int OUT_W     = hsv_pkg::HUE_W + hsv_pkg::SAT_W + hsv_pkg::CHAN_W;

    logic                       pipe_en;
    logic                       prep_valid;
    hsv_pkg::prep_word_t        prep_word;
    logic                       div_valid;
    logic                       div_grey;
    logic [hsv_pkg::CHAN_W-1:0] div_bright;
    logic [QBITS-1:0]           div_sat_q;
    logic [QBITS-1:0]           div_hue_q;

    logic [QBITS-1:0]           sat_full, hue_full;
    logic [hsv_pkg::HUE_W-1:0]  res_hue;
    logic [hsv_pkg::SAT_W-1:0]  res_sat;
    logic [OUT_W-1:0]           res_word;
    logic                       res_take;

    logic                       out_valid_reg, skid_valid_reg;
    logic [OUT_W-1:0]           out_data_reg, skid_data_reg;

    // pipeline moves whenever the skid stage is free
    assign pipe_en  = !skid_valid_reg;
    assign s_tready = pipe_en;

    hsv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .red       (s_tdata[7:0]),
        .green     (s_tdata[15:8]),
        .blue      (s_tdata[23:16]),
        .out_valid (prep_valid),
        .out_word  (prep_word)
    );

    hsv_div #(
        .QBITS (QBITS)
    ) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (prep_valid),
        .in_word    (prep_word),
        .out_valid  (div_valid),
        .out_grey   (div_grey),
        .out_bright (div_bright),
        .out_sat_q  (div_sat_q),
        .out_hue_q  (div_hue_q)
    );

    // rescale quotients; grey pixels read zero hue and saturation
    always_comb begin
        sat_full = div_sat_q >> SAT_SHIFT;
        hue_full = div_hue_q >> HUE_SHIFT;
        res_sat  = div_grey ? '0 : sat_full[hsv_pkg::SAT_W-1:0];
        res_hue  = div_grey ? '0 : hue_full[hsv_pkg::HUE_W-1:0];
        res_word = {div_bright, res_sat, res_hue};
        res_take = div_valid && pipe_en;
    end

    // output register and skid stage, valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || res_take;
            skid_valid_reg <= 1'b0;
        end else if (res_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid stage, data
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_word;
        end else if (res_take) begin
            skid_data_reg <= res_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // skid stage only fills behind a waiting output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without output word");

    // a word arriving at a stalled output lands in the skid stage
    a_skid_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && res_take) |=> skid_valid_reg)
        else $error("word lost at stalled output");

    // zero saturation only for grey pixels, which have zero hue
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[31:16] == 16'd0) |-> (out_data_reg[15:0] == 16'd0))
        else $error("zero saturation with nonzero hue");
`endif

endmodule

/* dv/rgb_to_hsv_converter_unit_tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// rgb_to_hsv_converter_unit_tb: self-checking bench for the RGB to HSV unit
// Pixels go in over the s_ stream and are predicted on acceptance; every
// HSV word out of m_ is checked field by field against the oldest
// prediction. Both ends idle in random bursts, the sender drains the pipe
// now and then, and the run ends with a stretch at full rate.
// ============================================================================
module rgb_to_hsv_converter_unit_tb;

    localparam int FRAC_BITS      = 16;
    localparam int SAT_FULL       = 65535;
    localparam int PIPE_LATENCY   = FRAC_BITS + 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM     = 1650;
    localparam int CALM_TAIL      = 150;

    // one pixel waiting to be sent, with its pacing controls
    typedef struct {
        logic [hsv_pkg::CHAN_W-1:0] red;
        logic [hsv_pkg::CHAN_W-1:0] green;
        logic [hsv_pkg::CHAN_W-1:0] blue;
        int                         gap;    // idle cycles before this pixel
        bit                         drain;  // hold until every result is back
        bit                         calm;   // no idling on either side
    } pixel_t;

    // expected HSV word
    typedef struct {
        logic [hsv_pkg::HUE_W-1:0]  hue;
        logic [hsv_pkg::SAT_W-1:0]  sat;
        logic [hsv_pkg::CHAN_W-1:0] bright;
    } hsv_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // red[7:0], green[15:8], blue[23:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // hue[15:0], saturation[31:16], brightness[39:32]

    pixel_t pixel_queue[$];
    hsv_t   hsv_expected[$];

    int  err_cnt      = 0;
    int  pixels_sent  = 0;
    int  words_seen   = 0;
    int  grey_sent    = 0;
    int  wrap_sent    = 0;
    int  drains_done  = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  idle_cycles  = 0;
    bit  calm_phase   = 1'b0;

    rgb_to_hsv_converter_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock and the single reset at start
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // exact integer HSV of one pixel
    function automatic hsv_t hsv_of(input logic [hsv_pkg::CHAN_W-1:0] r, g, b);
        logic [63:0] hi, lo, d, num, quo;
        hsv_t        res;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        d  = hi - lo;
        res.bright = hi[hsv_pkg::CHAN_W-1:0];
        quo = (hi == 0) ? 64'd0 : (d * SAT_FULL) / hi;
        res.sat = quo[hsv_pkg::SAT_W-1:0];
        quo = '0;
        if (d != 0) begin
            // sector offset plus signed difference, always in [0, 6d)
            if (hi == r) begin
                if (g >= b)
                    num = g - b;
                else
                    num = 6 * d - (b - g);
            end else if (hi == g) begin
                num = 2 * d + b - r;
            end else begin
                num = 4 * d + r - g;
            end
            quo = (num << FRAC_BITS) / (6 * d);
        end
        res.hue = quo[hsv_pkg::HUE_W-1:0];
        return res;
    endfunction

    task automatic add_pixel(input int r, g, b, gap, input bit drain, calm);
        pixel_t p;
        p.red   = r[hsv_pkg::CHAN_W-1:0];
        p.green = g[hsv_pkg::CHAN_W-1:0];
        p.blue  = b[hsv_pkg::CHAN_W-1:0];
        p.gap   = gap;
        p.drain = drain;
        p.calm  = calm;
        pixel_queue.push_back(p);
    endtask

    // stimulus: directed corners, then random pixels in paced segments
    initial begin
        int  r, g, b, v, w, gap;
        bit  calm;
        int  corner[4];
        corner = '{0, 1, 254, 255};

        // black, white, grey, primaries, sector ties and the red wrap
        add_pixel(0,   0,   0,   0, 0, 0);
        add_pixel(255, 255, 255, 0, 0, 0);
        add_pixel(128, 128, 128, 2, 0, 0);
        add_pixel(1,   1,   1,   0, 0, 0);
        add_pixel(255, 0,   0,   0, 0, 0);
        add_pixel(0,   255, 0,   0, 0, 0);
        add_pixel(0,   0,   255, 5, 0, 0);
        add_pixel(255, 0,   1,   0, 0, 0);
        add_pixel(255, 1,   0,   0, 0, 0);
        add_pixel(255, 255, 0,   0, 0, 0);
        add_pixel(0,   255, 255, 0, 1, 0);
        add_pixel(255, 0,   255, 0, 0, 0);
        add_pixel(1,   0,   0,   0, 0, 0);
        add_pixel(0,   1,   0,   0, 0, 0);
        add_pixel(0,   0,   1,   0, 0, 0);
        add_pixel(255, 254, 0,   0, 0, 0);
        add_pixel(254, 255, 255, 0, 0, 0);
        add_pixel(170, 85,  255, 0, 0, 0);
        add_pixel(85,  170, 85,  0, 0, 0);
        add_pixel(200, 10,  199, 0, 0, 0);

        calm = 1'b0;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            // pacing changes every segment; the tail runs flat out
            if (i % 110 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (i >= NUM_RANDOM - CALM_TAIL)
                calm = 1'b1;
            gap = (!calm && $urandom_range(0, 6) == 0) ? $urandom_range(1, 14) : 0;
            r = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            b = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                7: begin
                    g = r;
                    b = r;
                end
                8: begin
                    v = $urandom_range(0, 255);
                    w = $urandom_range(0, 255);
                    case ($urandom_range(0, 2))
                        0: begin r = v; g = v; b = w; end
                        1: begin g = v; b = v; r = w; end
                        default: begin r = v; b = v; g = w; end
                    endcase
                end
                9: begin
                    r = corner[$urandom_range(0, 3)];
                    g = corner[$urandom_range(0, 3)];
                    b = corner[$urandom_range(0, 3)];
                end
                default: ;
            endcase
            add_pixel(r, g, b, gap, (i % 400 == 200), calm);
        end

        // wait for the last pixel to go in and its word to come out
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || hsv_expected.size() != 0);
        repeat (PIPE_LATENCY * 2) @(posedge aclk);

        if (hsv_expected.size() != 0) begin
            $error("%0d predicted words never arrived", hsv_expected.size());
            err_cnt++;
        end
        $display("Converted %0d pixels (%0d grey, %0d in the wrapped red sector),",
                 pixels_sent, grey_sent, wrap_sent);
        $display("checked %0d HSV words across %0d full pipeline drains", words_seen,
                 drains_done);
        if (err_cnt == 0)
            $display("rgb_to_hsv_converter_unit verification clean");
        else
            $display("rgb_to_hsv_converter_unit verification failed");
        $finish;
    end

    // pixel driver: predicts each accepted word, then loads the next one
    always @(posedge aclk) begin
        pixel_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                hsv_expected.push_back(hsv_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
                pixels_sent++;
                if (s_tdata[7:0] == s_tdata[15:8] && s_tdata[15:8] == s_tdata[23:16])
                    grey_sent++;
                if (s_tdata[7:0] >= s_tdata[15:8] && s_tdata[7:0] >= s_tdata[23:16] &&
                    s_tdata[15:8] < s_tdata[23:16])
                    wrap_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pixel_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pixel_queue[0].drain && hsv_expected.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else if (pixel_queue[0].gap != 0) begin
                    gap_left = pixel_queue[0].gap - 1;
                    pixel_queue[0].gap = 0;
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = pixel_queue.pop_front();
                    if (nxt.drain)
                        drains_done++;
                    calm_phase = nxt.calm;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.blue, nxt.green, nxt.red};
                end
            end
        end
    end

    // result monitor: field checks against the oldest prediction, random stalls
    always @(posedge aclk) begin
        hsv_t exp_word;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                words_seen++;
                if (hsv_expected.size() == 0) begin
                    $error("HSV word 0x%010h with no pixel pending", m_tdata);
                    err_cnt++;
                end else begin
                    exp_word = hsv_expected.pop_front();
                    if (m_tdata[15:0] !== exp_word.hue) begin
                        $error("hue mismatch: expected %0d, got %0d",
                               exp_word.hue, m_tdata[15:0]);
                        err_cnt++;
                    end
                    if (m_tdata[31:16] !== exp_word.sat) begin
                        $error("saturation mismatch: expected %0d, got %0d",
                               exp_word.sat, m_tdata[31:16]);
                        err_cnt++;
                    end
                    if (m_tdata[39:32] !== exp_word.bright) begin
                        $error("brightness mismatch: expected %0d, got %0d",
                               exp_word.bright, m_tdata[39:32]);
                        err_cnt++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("rgb_to_hsv_converter_unit verification failed");
                $finish;
            end
        end
    end

endmodule
